### rtl/core/assert_macros.svh
// Assertion macros for the checker file of the local maximum marker.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is low.
`define WLM_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds through reset.
`define WLM_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/wlm_pkg.sv
// Shared constants and types of the window local maximum marker.
// No dependencies; imported by every module of the block but wlm_ram.
`default_nettype none

package wlm_pkg;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     RESET_DIM        = 11'd256;

    // parameter defaults
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_RADIUS      = 1;
    localparam int DEF_SAMPLE_BITS = 16;

    // result word
    localparam int POS_W        = 10;
    localparam int M_TDATA_W    = 24;
    localparam int M_TDATA_PAD  = M_TDATA_W - 2 * POS_W;

    // result queue and settle time of the derived frame registers
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);
    localparam int Q_CW          = $clog2(Q_DEPTH + 1);
    localparam int SETTLE_CYCLES = 3;
    localparam int SETTLE_W      = 2;

    typedef struct packed {
        logic adv;   // word moves the frame forward
        logic emit;  // word releases a result
        logic last;  // word is the last one of the frame
    } t_step;

    typedef struct packed {
        logic a_res; // result pending in the window load stage
        logic b_res; // result pending in the compare stage
    } t_pipe_stat;

    typedef struct packed {
        logic             is_max;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/wlm_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
// No dependencies.
`default_nettype none

module wlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/wlm_ctrl.sv
// Frame control: config registers, clamped dimensions, stream and result counters.
// Depends on wlm_pkg.
`default_nettype none

module wlm_ctrl
    import wlm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int RADIUS    = DEF_RADIUS,
    localparam int DIM_W    = $clog2(MAX_WIDTH + 1),
    localparam int AW       = $clog2(MAX_WIDTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic                 i_fill,
    input  wire logic [Q_CW-1:0]      i_q_count,
    input  wire t_pipe_stat           i_stat,
    output t_step                     o_step,
    output logic      [AW-1:0]        o_addr,
    output logic      [DIM_W-1:0]     o_row,
    output logic      [DIM_W-1:0]     o_col,
    output logic      [DIM_W-1:0]     o_w,
    output logic      [DIM_W-1:0]     o_h
);

    localparam int AREA_W = 2 * DIM_W;
    localparam int LAG_W  = DIM_W + $clog2(RADIUS + 1) + 1;
    localparam int KW     = 2 * DIM_W + 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            return DIM_W'(MAX_WIDTH);
        end else begin
            return DIM_W'(v);
        end
    endfunction

    logic [CFG_W-1:0]    r_raw_w, r_raw_h;
    logic [SETTLE_W-1:0] r_settle;
    logic [DIM_W-1:0]    r_wc, r_hc;
    logic [AREA_W-1:0]   r_area;
    logic [LAG_W-1:0]    r_lag;
    logic [KW-1:0]       r_total;
    logic [KW-1:0]       r_k, n_k;
    logic [DIM_W-1:0]    r_in_col, n_in_col;
    logic [DIM_W-1:0]    r_p_row, n_p_row;
    logic [DIM_W-1:0]    r_p_col, n_p_col;

    logic cfg_hit;
    logic accept;
    logic in_frame;
    logic bubble;
    logic emit;
    logic last;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);

    // credit check: queue entries plus results still in flight
    assign o_s_tready = (r_settle == '0) &&
        ((32'(i_q_count) + 32'(i_stat.a_res) + 32'(i_stat.b_res)) < Q_DEPTH);

    assign accept   = i_s_tvalid && o_s_tready;
    assign in_frame = r_k < KW'(r_area);
    assign bubble   = in_frame && i_fill;
    assign emit     = r_k >= KW'(r_lag);
    assign last     = r_k == (r_total - KW'(1));

    assign o_step = '{adv: accept && !bubble, emit: emit, last: last};
    assign o_addr = r_in_col[AW-1:0];
    assign o_row  = r_p_row;
    assign o_col  = r_p_col;
    assign o_w    = r_wc;
    assign o_h    = r_hc;

    // derived frame sizes, one step per cycle
    always_ff @(posedge i_clk) begin
        r_wc    <= clamp_dim(r_raw_w);
        r_hc    <= clamp_dim(r_raw_h);
        r_area  <= AREA_W'(r_wc) * AREA_W'(r_hc);
        r_lag   <= LAG_W'(RADIUS * int'(r_wc) + RADIUS);
        r_total <= KW'(r_area) + KW'(r_lag);
    end

    always_comb begin
        n_k      = r_k;
        n_in_col = r_in_col;
        n_p_row  = r_p_row;
        n_p_col  = r_p_col;
        if (o_step.adv) begin
            if (last) begin
                n_k      = '0;
                n_in_col = '0;
                n_p_row  = '0;
                n_p_col  = '0;
            end else begin
                n_k = r_k + KW'(1);
                if (r_in_col == r_wc - DIM_W'(1)) begin
                    n_in_col = '0;
                end else begin
                    n_in_col = r_in_col + DIM_W'(1);
                end
                if (emit) begin
                    if (r_p_col == r_wc - DIM_W'(1)) begin
                        n_p_col = '0;
                        n_p_row = r_p_row + DIM_W'(1);
                    end else begin
                        n_p_col = r_p_col + DIM_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_w  <= RESET_DIM;
            r_raw_h  <= RESET_DIM;
            r_settle <= SETTLE_W'(SETTLE_CYCLES);
            r_k      <= '0;
            r_in_col <= '0;
            r_p_row  <= '0;
            r_p_col  <= '0;
        end else if (cfg_hit) begin
            // a write restarts the frame and holds input off while sizes settle
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_raw_w <= i_cfg_data;
            end else begin
                r_raw_h <= i_cfg_data;
            end
            r_settle <= SETTLE_W'(SETTLE_CYCLES);
            r_k      <= '0;
            r_in_col <= '0;
            r_p_row  <= '0;
            r_p_col  <= '0;
        end else begin
            if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
            r_k      <= n_k;
            r_in_col <= n_in_col;
            r_p_row  <= n_p_row;
            r_p_col  <= n_p_col;
        end
    end

endmodule

`default_nettype wire

### rtl/core/wlm_window.sv
// Line buffers, window registers and centre compare of the local maximum marker.
// Depends on wlm_pkg and wlm_ram.
`default_nettype none

module wlm_window
    import wlm_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int RADIUS      = DEF_RADIUS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int DIM_W      = $clog2(MAX_WIDTH + 1),
    localparam int AW         = $clog2(MAX_WIDTH)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_step                         i_step,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic        [AW-1:0]          i_addr,
    input  wire logic        [DIM_W-1:0]       i_row,
    input  wire logic        [DIM_W-1:0]       i_col,
    input  wire logic        [DIM_W-1:0]       i_w,
    input  wire logic        [DIM_W-1:0]       i_h,
    output t_pipe_stat                         o_stat,
    output logic                               o_res_valid,
    output logic                               o_is_max,
    output logic             [DIM_W-1:0]       o_row,
    output logic             [DIM_W-1:0]       o_col,
    output logic                               o_last
);

    localparam int S     = 2 * RADIUS + 1;
    localparam int C     = RADIUS * S + RADIUS;
    localparam int LB_W  = 2 * RADIUS * SAMPLE_BITS;
    localparam int EXT_W = DIM_W + 1;

    // stage A: word registered, line buffer read in flight
    logic                          r_a_valid;
    logic                          r_a_emit;
    logic                          r_a_last;
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    logic        [AW-1:0]          r_a_addr;
    logic        [DIM_W-1:0]       r_a_row, r_a_col;
    logic                          r_a_fwd;
    logic        [LB_W-1:0]        r_a_fwd_data;

    // stage B: window loaded, compare
    logic                          r_b_valid;
    logic                          r_b_last;
    logic        [DIM_W-1:0]       r_b_row, r_b_col;
    logic signed [SAMPLE_BITS-1:0] r_win [S][S];

    logic        [LB_W-1:0]        ram_rd;
    logic        [LB_W-1:0]        col_data;
    logic        [LB_W-1:0]        a_wdata;
    logic signed [SAMPLE_BITS-1:0] newcol [S];
    logic signed [SAMPLE_BITS-1:0] ctr;
    logic        [S-1:0]           row_ok, col_ok;
    logic                          mark;

    // line buffer t delays by t+1 rows; packed side by side in one RAM
    wlm_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_a_valid),
        .i_waddr (r_a_addr),
        .i_wdata (a_wdata),
        .i_re    (i_step.adv),
        .i_raddr (i_addr),
        .o_rdata (ram_rd)
    );

    // a read that hits the address written the same cycle takes the new data
    assign col_data = r_a_fwd ? r_a_fwd_data : ram_rd;

    always_comb begin
        a_wdata[SAMPLE_BITS-1:0] = r_a_sample;
        for (int t = 1; t < 2 * RADIUS; t++) begin
            a_wdata[t*SAMPLE_BITS +: SAMPLE_BITS] = col_data[(t-1)*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    always_comb begin
        newcol[S-1] = r_a_sample;
        for (int i = 0; i < S - 1; i++) begin
            newcol[i] = col_data[(S-2-i)*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_step.adv;
            r_b_valid <= r_a_valid && r_a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.adv) begin
            r_a_emit     <= i_step.emit;
            r_a_last     <= i_step.last;
            r_a_sample   <= i_sample;
            r_a_addr     <= i_addr;
            r_a_row      <= i_row;
            r_a_col      <= i_col;
            r_a_fwd      <= r_a_valid && (i_addr == r_a_addr);
            r_a_fwd_data <= a_wdata;
        end
        if (r_a_valid) begin
            r_b_last <= r_a_last;
            r_b_row  <= r_a_row;
            r_b_col  <= r_a_col;
            for (int i = 0; i < S; i++) begin
                for (int j = 0; j < S - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][S-1] <= newcol[i];
            end
        end
    end

    assign ctr = r_win[RADIUS][RADIUS];

    // in-frame masks for window rows and columns
    always_comb begin
        for (int i = 0; i < S; i++) begin
            if (i < RADIUS) begin
                row_ok[i] = r_b_row >= DIM_W'(RADIUS - i);
                col_ok[i] = r_b_col >= DIM_W'(RADIUS - i);
            end else begin
                row_ok[i] = ({1'b0, r_b_row} + EXT_W'(i - RADIUS)) < {1'b0, i_h};
                col_ok[i] = ({1'b0, r_b_col} + EXT_W'(i - RADIUS)) < {1'b0, i_w};
            end
        end
    end

    // first maximum: strictly above earlier samples, not below later ones
    always_comb begin
        logic vld;
        logic beats;
        mark = 1'b1;
        for (int i = 0; i < S; i++) begin
            for (int j = 0; j < S; j++) begin
                vld   = row_ok[i] && col_ok[j];
                beats = (i * S + j < C) ? (ctr > r_win[i][j]) : (ctr >= r_win[i][j]);
                if (i * S + j != C && vld && !beats) begin
                    mark = 1'b0;
                end
            end
        end
    end

    assign o_stat      = '{a_res: r_a_valid && r_a_emit, b_res: r_b_valid};
    assign o_res_valid = r_b_valid;
    assign o_is_max    = mark;
    assign o_row       = r_b_row;
    assign o_col       = r_b_col;
    assign o_last      = r_b_last;

endmodule

`default_nettype wire

### rtl/core/wlm_out_q.sv
// Small result queue that decouples the compare stage from the output handshake.
// Depends on wlm_pkg.
`default_nettype none

module wlm_out_q
    import wlm_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire t_result         i_res,
    output logic [Q_CW-1:0]      o_count,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output t_result              o_res
);

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0]   r_count, n_count;
    logic              pop;

    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = r_count != '0;
    assign o_res   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/core/window_local_maximum_marker.sv
// Local maximum marker: one word per cycle sustained, on both stream sides, while the
// queue has credit and the sink is ready. A position's result is released RADIUS rows
// plus RADIUS words after its sample and then passes the window load, compare and queue.
// Reset (synchronous, active low) restores 256 x 256 and restarts the frame; input is
// held off while sizes settle after reset and every size write. Line buffers are not cleared.
`default_nettype none

module window_local_maximum_marker
    import wlm_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int RADIUS       = DEF_RADIUS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration writes: index 0 frame_width, index 1 frame_height
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // sample stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // sample
    input  wire logic                 i_s_tuser,   // fill
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,   // out_row, out_col
    output logic                      o_m_tuser,   // is_maximum
    output logic                      o_m_tlast    // frame_last
);

    localparam int DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(MAX_WIDTH);

    t_step                         step;
    t_pipe_stat                    stat;
    logic        [AW-1:0]          addr;
    logic        [DIM_W-1:0]       p_row, p_col;
    logic        [DIM_W-1:0]       dim_w, dim_h;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [Q_CW-1:0]        q_count;
    logic                          res_valid;
    logic                          res_is_max;
    logic        [DIM_W-1:0]       res_row, res_col;
    logic                          res_last;
    t_result                       res_in;
    t_result                       res_out;

    assign sample = signed'(i_s_tdata[SAMPLE_BITS-1:0]);

    // Frame counters. Word k of a frame stores its sample while k < W*H, and
    // releases the result of position k - (RADIUS*W + RADIUS) once that is
    // not negative. A fill word inside the frame is a bubble: taken, no effect.
    // A frame ends after W*H + RADIUS*W + RADIUS counted words.
    wlm_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_fill      (i_s_tuser),
        .i_q_count   (q_count),
        .i_stat      (stat),
        .o_step      (step),
        .o_addr      (addr),
        .o_row       (p_row),
        .o_col       (p_col),
        .o_w         (dim_w),
        .o_h         (dim_h)
    );

    // Window path. 2*RADIUS line buffers indexed by column feed one new column
    // per counted word into the window shift registers; the centre is then
    // compared against every in-frame neighbor in parallel. Out-of-frame taps
    // are masked, so words in the flush region may carry any sample.
    wlm_window #(
        .MAX_WIDTH   (MAX_WIDTH),
        .RADIUS      (RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_sample    (sample),
        .i_addr      (addr),
        .i_row       (p_row),
        .i_col       (p_col),
        .i_w         (dim_w),
        .i_h         (dim_h),
        .o_stat      (stat),
        .o_res_valid (res_valid),
        .o_is_max    (res_is_max),
        .o_row       (res_row),
        .o_col       (res_col),
        .o_last      (res_last)
    );

    assign res_in = '{
        is_max: res_is_max,
        row:    POS_W'(res_row),
        col:    POS_W'(res_col),
        last:   res_last
    };

    // Results wait here; input keeps flowing while the queue has credit
    // for every result still in the window path.
    wlm_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res_in),
        .o_count (q_count),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res_out)
    );

    assign o_m_tdata = {{M_TDATA_PAD{1'b0}}, res_out.col, res_out.row};
    assign o_m_tuser = res_out.is_max;
    assign o_m_tlast = res_out.last;

endmodule

`default_nettype wire

### rtl/core/wlm_checker.sv
// Port-level checks of the local maximum marker, bound to the top level.
// Depends on wlm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wlm_checker
    import wlm_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic                 o_m_tlast
);

    `WLM_ASSERT_RST(a_m_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result word changed")

    `WLM_ASSERT(a_rst_settle, i_clk, !i_rst_n |=> !o_s_tready, "input taken right after reset")

    `WLM_ASSERT_RST(a_cfg_settle, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT) |=> !o_s_tready, "input taken while frame size settles")

    `WLM_ASSERT_RST(a_frame_wrap, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast |=> !o_m_tvalid || o_m_tdata[2*POS_W-1:0] == '0, "frame did not restart at origin")

    `WLM_ASSERT_RST(a_col_step, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast |=> !o_m_tvalid || o_m_tdata[2*POS_W-1:POS_W] == '0 || o_m_tdata[2*POS_W-1:POS_W] == $past(o_m_tdata[2*POS_W-1:POS_W]) + 10'd1, "column skipped")

endmodule

bind window_local_maximum_marker wlm_checker u_wlm_checker (.*);

`default_nettype wire

### tb/sv/window_local_maximum_marker_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the local maximum marker: follows size writes and accepted sample words,
// predicts every marker result and compares it with the result stream.
// Depends on wlm_pkg for the port widths, the register indexes and the result struct.
module window_local_maximum_marker_checker
    import wlm_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int RADIUS      = DEF_RADIUS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic                 i_m_tuser,
    input  logic                 i_m_tlast,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    // ring wide enough for 2R+2 rows of the widest frame
    localparam int RING_DEPTH = (2 * RADIUS + 2) * MAX_WIDTH;

    logic [CFG_W-1:0]              width_reg  = RESET_DIM;
    logic [CFG_W-1:0]              height_reg = RESET_DIM;
    int                            frame_pos  = 0;
    logic signed [SAMPLE_BITS-1:0] sample_ring [RING_DEPTH];
    t_result                       pending_marks [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // zero acts as one, anything past the line buffers as the widest
    function automatic int usable_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return int'(v);
    endfunction

    // first maximum in row-major scan of the window; strictly greater replaces
    function automatic t_result judge_window(input int pos, input int w, input int h);
        int                            pr, pc, r, c, di, dj;
        logic signed [SAMPLE_BITS-1:0] best, v;
        logic                          have, centre_wins;
        t_result                       res;
        pr          = pos / w;
        pc          = pos % w;
        have        = 1'b0;
        best        = '0;
        centre_wins = 1'b0;
        for (di = -RADIUS; di <= RADIUS; di++) begin
            for (dj = -RADIUS; dj <= RADIUS; dj++) begin
                r = pr + di;
                c = pc + dj;
                if (r >= 0 && c >= 0 && r < h && c < w) begin
                    v = sample_ring[(r * w + c) % RING_DEPTH];
                    if (!have || v > best) begin
                        have        = 1'b1;
                        best        = v;
                        centre_wins = (di == 0 && dj == 0);
                    end
                end
            end
        end
        res.is_max = centre_wins;
        res.row    = pr[POS_W-1:0];
        res.col    = pc[POS_W-1:0];
        res.last   = (pos == w * h - 1);
        return res;
    endfunction

    task automatic take_word(input logic signed [SAMPLE_BITS-1:0] value, input logic fill);
        int w, h, area, lag;
        w    = usable_dim(width_reg);
        h    = usable_dim(height_reg);
        area = w * h;
        lag  = RADIUS * w + RADIUS;
        if (frame_pos < area) begin
            if (fill) return;   // bubble inside the frame: no effect at all
            sample_ring[frame_pos % RING_DEPTH] = value;
        end
        if (frame_pos >= lag && frame_pos - lag < area)
            pending_marks.insert(pending_marks.size(), judge_window(frame_pos - lag, w, h));
        frame_pos = (frame_pos + 1 >= area + lag) ? 0 : frame_pos + 1;
    endtask

    task automatic check_mark();
        t_result seen, want;
        seen.is_max = i_m_tuser;
        seen.row    = i_m_tdata[POS_W-1:0];
        seen.col    = i_m_tdata[2*POS_W-1:POS_W];
        seen.last   = i_m_tlast;
        if (pending_marks.size() == 0) begin
            o_mismatches = o_mismatches + 1;
            if (o_mismatches <= 10)
                $display("%0t: unexpected mark max=%0b row=%0d col=%0d last=%0b", $realtime,
                         seen.is_max, seen.row, seen.col, seen.last);
            return;
        end
        want = pending_marks.pop_front();
        if (seen.is_max !== want.is_max || seen.row !== want.row ||
            seen.col !== want.col || seen.last !== want.last) begin
            o_mismatches = o_mismatches + 1;
            if (o_mismatches <= 10)
                $display("%0t: mark mismatch, expected max=%0b row=%0d col=%0d last=%0b, %s",
                         $realtime, want.is_max, want.row, want.col, want.last,
                         $sformatf("got max=%0b row=%0d col=%0d last=%0b",
                                   seen.is_max, seen.row, seen.col, seen.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RESET_DIM;
            height_reg = RESET_DIM;
            frame_pos  = 0;
            pending_marks.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_mark();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg = i_cfg_data;
                        frame_pos = 0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                        frame_pos  = 0;
                    end
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) take_word(i_s_tdata[SAMPLE_BITS-1:0], i_s_tuser);
        end
        o_outstanding = pending_marks.size();
    end

endmodule

### tb/sv/tb_window_local_maximum_marker.sv
`timescale 1ns / 1ps
// Top of the local maximum marker testbench: clock, reset, size writes, sample stream and
// result sink with random gaps, watchdog and verdict.
// Depends on wlm_pkg, the marker RTL and window_local_maximum_marker_checker.
module tb_window_local_maximum_marker;
    import wlm_pkg::*;

    localparam int MAX_WIDTH   = DEF_MAX_WIDTH;
    localparam int RADIUS      = DEF_RADIUS;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int STALL_LIMIT  = 1000; // quiet cycles before the run is declared hung
    localparam int DRAIN_CYCLES = 16;   // settle time before a size write and at the end
    localparam int RANDOM_ITEMS = 120;  // counted words in small random frames

    typedef enum int {CONTENT_WIDE, CONTENT_TIES, CONTENT_RAILS} t_content;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 i_m_tready  = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;

    int mark_errors;
    int mark_backlog;

    // effective frame size as the block sees it, for sizing the stimulus
    int cur_w           = RESET_DIM;
    int cur_h           = RESET_DIM;
    int random_pixels   = 0;
    int source_idle_pct = 0;
    int sink_idle_pct   = 0;
    int sink_hold       = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    window_local_maximum_marker #(
        .MAX_WIDTH   (MAX_WIDTH),
        .RADIUS      (RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // sample
        .i_s_tuser   (i_s_tuser),   // fill
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // out_row, out_col
        .o_m_tuser   (o_m_tuser),   // is_maximum
        .o_m_tlast   (o_m_tlast)    // frame_last
    );

    window_local_maximum_marker_checker #(
        .MAX_WIDTH   (MAX_WIDTH),
        .RADIUS      (RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_m_tlast     (o_m_tlast),
        .o_mismatches  (mark_errors),
        .o_outstanding (mark_backlog)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(99) < 80) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sample content: full range, a narrow band around zero so that ties are
    // frequent, or only the rails and the values next to zero.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input t_content mix);
        int near;
        case (mix)
            CONTENT_TIES: begin
                near = $urandom_range(4);
                near = near - 2;
                return near[SAMPLE_BITS-1:0];
            end
            CONTENT_RAILS: begin
                case ($urandom_range(3))
                    0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Result sink: ready drops for a random stretch, or never while the pct is zero.
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold  <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
            sink_hold  <= gap_length() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Any word moved on any channel restarts the quiet count.
    wire any_word = (i_cfg_valid & o_cfg_ready) | (i_s_tvalid & o_s_tready) |
                    (o_m_tvalid & i_m_tready);

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (any_word) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Called at a falling edge. Leaves valid high after the handshake so that a
    // following word goes out back to back; whoever stops lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Same scheme for the sample stream, with an optional gap before the word.
    task automatic send_word(input logic [SAMPLE_BITS-1:0] value, input logic fill);
        if (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat (gap_length()) @(negedge i_clk);
        end
        i_s_tdata  <= value;
        i_s_tuser  <= fill;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Block idle: no word offered, every mark back, and the pipeline given time
    // to finish bubbles that never produce a mark.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (mark_backlog != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic spares);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        if (spares) begin
            write_reg(REG_SPARE_LO, CFG_W'($urandom));
            write_reg(REG_SPARE_HI, CFG_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
        cur_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        cur_h = (h == 0) ? 1 : (h > MAX_WIDTH) ? MAX_WIDTH : h;
    endtask

    // One full frame: pixels with the odd bubble mixed in, then the flush slots,
    // a few of which carry fill=0 and must still count as flush.
    task automatic send_frame(input t_content mix);
        int n;
        for (n = 0; n < cur_w * cur_h; n++) begin
            if ($urandom_range(99) < 6) send_word(pick_sample(CONTENT_WIDE), 1'b1);
            send_word(pick_sample(mix), 1'b0);
        end
        for (n = 0; n < RADIUS * cur_w + RADIUS; n++)
            send_word(pick_sample(CONTENT_WIDE), $urandom_range(99) >= 15);
    endtask

    initial begin : stimulus
        int                     phase;
        int                     frames;
        int                     n;
        t_content               mix;
        logic [SAMPLE_BITS-1:0] probe [9];
        // 3x3 probe: rails, ties on the top row and a tie behind the centre below
        probe = '{16'h7FFF, 16'h7FFF, 16'h8000,
                  16'h0000, 16'h0005, 16'h0005,
                  16'hFFFF, 16'h8000, 16'h0005};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Height only: the width still has its reset value of 256.
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        i_cfg_valid <= 1'b0;
        cur_w = RESET_DIM;
        cur_h = 1;
        source_idle_pct = 10;
        sink_idle_pct   = 10;
        send_frame(CONTENT_WIDE);

        // Directed 3x3 frame after writes to the spare indexes, with a bubble
        // holding the top value and a fill=0 word in the flush region.
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        set_size(CFG_W'(3), CFG_W'(3), 1'b1);
        for (n = 0; n < 9; n++) begin
            send_word(probe[n], 1'b0);
            if (n == 4) send_word(probe[0], 1'b1);
        end
        send_word(pick_sample(CONTENT_WIDE), 1'b1);
        send_word(pick_sample(CONTENT_WIDE), 1'b0);
        send_word('1, 1'b1);
        send_word('0, 1'b1);

        // Zero sizes act as a single pixel.
        set_size('0, '0, 1'b0);
        send_frame(CONTENT_RAILS);

        // Random part: small frames with random content and idling.
        phase = 0;
        while (phase < 2 || random_pixels < RANDOM_ITEMS) begin
            phase++;
            set_size(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)),
                     $urandom_range(99) < 20);
            mix             = t_content'($urandom_range(2));
            source_idle_pct = 10 * $urandom_range(3);
            sink_idle_pct   = 10 * $urandom_range(3);
            frames          = $urandom_range(1, 2);
            repeat (frames) send_frame(mix);
            random_pixels += frames * (cur_w * cur_h + RADIUS * cur_w + RADIUS);
        end

        wait_idle();
        if (mark_errors == 0 && mark_backlog == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
